### rtl/core/iaf_pkg.sv
`default_nettype none

package iaf_pkg;

  localparam int FF_ROM   = 64;
  localparam int FB_ROM   = 32;
  localparam int TAP_W    = 6;
  localparam int FB_IDX_W = 5;
  localparam int COEF_W   = 18;

  // The coefficient magnitudes sum to well below 2^18, so this many bits above
  // the sample width keep the accumulator exact.
  localparam int ACC_GUARD = 20;

  localparam int FEED_FORWARD_TAPS_DEF = 49;
  localparam int FEEDBACK_TAPS_DEF     = 21;
  localparam int SAMPLE_BITS_DEF       = 16;
  localparam int COEF_FRAC_BITS_DEF    = 14;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FF,
    S_FB,
    S_DRAIN,
    S_ROUND
  } iaf_state_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Feed-forward coefficients b[k], Q1.14.
  function automatic coef_t ff_coef(input logic [TAP_W-1:0] k);
    coef_t c;
    case (k)
      6'd0:  c = 18'sd35;
      6'd1:  c = 18'sd59;
      6'd2:  c = 18'sd95;
      6'd3:  c = 18'sd144;
      6'd4:  c = 18'sd205;
      6'd5:  c = 18'sd277;
      6'd6:  c = 18'sd360;
      6'd7:  c = 18'sd452;
      6'd8:  c = 18'sd552;
      6'd9:  c = 18'sd658;
      6'd10: c = 18'sd769;
      6'd11: c = 18'sd882;
      6'd12: c = 18'sd996;
      6'd13: c = 18'sd1108;
      6'd14: c = 18'sd1216;
      6'd15: c = 18'sd1318;
      6'd16: c = 18'sd1412;
      6'd17: c = 18'sd1496;
      6'd18: c = 18'sd1568;
      6'd19: c = 18'sd1626;
      6'd20: c = 18'sd1668;
      6'd21: c = 18'sd1694;
      6'd22: c = 18'sd1701;
      6'd23: c = 18'sd1690;
      6'd24: c = 18'sd1659;
      6'd25: c = 18'sd1609;
      6'd26: c = 18'sd1539;
      6'd27: c = 18'sd1450;
      6'd28: c = 18'sd1342;
      6'd29: c = 18'sd1216;
      6'd30: c = 18'sd1075;
      6'd31: c = 18'sd918;
      6'd32: c = 18'sd749;
      6'd33: c = 18'sd569;
      6'd34: c = 18'sd379;
      6'd35: c = 18'sd183;
      6'd36: c = -18'sd18;
      6'd37: c = -18'sd220;
      6'd38: c = -18'sd422;
      6'd39: c = -18'sd620;
      6'd40: c = -18'sd811;
      6'd41: c = -18'sd995;
      6'd42: c = -18'sd1167;
      6'd43: c = -18'sd1326;
      6'd44: c = -18'sd1469;
      6'd45: c = -18'sd1595;
      6'd46: c = -18'sd1702;
      6'd47: c = -18'sd1788;
      6'd48: c = -18'sd1853;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Feedback coefficients a[j], Q1.14; a[0] is implicit and never read.
  function automatic coef_t fb_coef(input logic [FB_IDX_W-1:0] j);
    coef_t c;
    case (j)
      5'd1:  c = -18'sd15565;
      5'd2:  c = 18'sd13926;
      5'd3:  c = -18'sd12288;
      5'd4:  c = 18'sd10650;
      5'd5:  c = -18'sd9011;
      5'd6:  c = 18'sd7373;
      5'd7:  c = -18'sd5734;
      5'd8:  c = 18'sd4096;
      5'd9:  c = -18'sd2458;
      5'd10: c = 18'sd819;
      5'd11: c = -18'sd492;
      5'd12: c = 18'sd164;
      5'd13: c = -18'sd131;
      5'd14: c = 18'sd82;
      5'd15: c = -18'sd49;
      5'd16: c = 18'sd16;
      5'd17: c = -18'sd13;
      5'd18: c = 18'sd8;
      5'd19: c = -18'sd5;
      5'd20: c = 18'sd2;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/iaf_ram.sv
`default_nettype none

module iaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/iir_audio_filter.sv
// Direct form I IIR audio filter with one shared multiply-accumulate unit.
// Input channel: in_valid/in_ready carry in_sample_in and in_start_of_signal;
// a set start flag clears both sample histories before that sample is used.
// Output channel: out_valid/out_ready carry out_sample_out and out_saturated.
// After a sample's transfer, its taps pass through the MAC one per cycle, the
// read and multiply stages drain, and the rounding step rounds, saturates and
// writes the result back to the output register. in_ready is high only in the
// idle state, so the next sample is not taken until the last one is written back.
// Throughput is set by the single multiplier and the one read port of each
// history RAM. Histories live in two circular RAMs; a fill count per RAM marks
// how many entries hold samples since the last clear, and older taps read as 0.
// Reset empties both histories and the output register at once.
// The output register holds a finished result while the receiver stalls; the
// next sample is still taken and processed, and waits in the rounding step
// until the held result has been transferred.
`default_nettype none

module iir_audio_filter #(
  parameter int FEED_FORWARD_TAPS = iaf_pkg::FEED_FORWARD_TAPS_DEF,
  parameter int FEEDBACK_TAPS     = iaf_pkg::FEEDBACK_TAPS_DEF,
  parameter int SAMPLE_BITS       = iaf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS    = iaf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                   in_start_of_signal,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample_out,
  output logic                   out_saturated
);

  import iaf_pkg::*;

  localparam int IN_HIST   = FEED_FORWARD_TAPS - 1;
  localparam int OUT_HIST  = FEEDBACK_TAPS - 1;
  localparam int IN_DEPTH  = (IN_HIST > 0) ? IN_HIST : 1;
  localparam int IN_AW     = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int OUT_AW    = (OUT_HIST > 1) ? $clog2(OUT_HIST) : 1;
  localparam int ACC_W     = SAMPLE_BITS + ACC_GUARD;
  localparam int PROD_W    = SAMPLE_BITS + COEF_W;
  localparam int YW        = ACC_W - COEF_FRAC_BITS;

  localparam logic [TAP_W-1:0]  FF_LAST  = TAP_W'(FEED_FORWARD_TAPS - 1);
  localparam logic [TAP_W-1:0]  FB_LAST  = TAP_W'(FEEDBACK_TAPS - 1);
  localparam logic [TAP_W-1:0]  IN_FULL  = TAP_W'(IN_HIST);
  localparam logic [TAP_W-1:0]  OUT_FULL = TAP_W'(OUT_HIST);
  localparam logic [IN_AW-1:0]  IN_TOP   = IN_AW'(IN_DEPTH - 1);
  localparam logic [OUT_AW-1:0] OUT_TOP  = OUT_AW'(OUT_HIST - 1);
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  iaf_state_t state_r, state_nxt;

  logic [TAP_W-1:0]  idx_r, idx_nxt;
  logic [IN_AW-1:0]  in_rp_r, in_rp_nxt, in_wp_r;
  logic [OUT_AW-1:0] out_rp_r, out_rp_nxt, out_wp_r;
  logic [TAP_W-1:0]  fill_in_r, fill_out_r;

  logic signed [SAMPLE_BITS-1:0] x_r;

  // Tap issue controls, then the read/multiply stage and the product stage.
  logic        issue, issue_use_x, issue_zero, issue_sel_out;
  coef_t       issue_coef;
  logic        b_valid_r, b_use_x_r, b_zero_r, b_sel_out_r;
  coef_t       coef_b_r;
  logic        p_valid_r;
  logic signed [PROD_W-1:0] prod_r, prod_w;
  logic signed [ACC_W-1:0]  acc_r;

  logic accept, finish;

  logic [SAMPLE_BITS-1:0]        in_rd, out_rd, b_data;
  logic signed [SAMPLE_BITS-1:0] operand;

  logic signed [ACC_W-1:0]       rnd;
  logic [YW-1:0]                 y_full;
  logic [YW-SAMPLE_BITS:0]       y_hi;
  logic                          y_sat;
  logic [SAMPLE_BITS-1:0]        y_val;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_sat_r;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    in_rp_nxt     = in_rp_r;
    out_rp_nxt    = out_rp_r;
    issue         = 1'b0;
    issue_use_x   = 1'b0;
    issue_zero    = 1'b0;
    issue_sel_out = 1'b0;
    issue_coef    = ff_coef(idx_r);
    finish        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FF;
          idx_nxt   = '0;
          in_rp_nxt = (in_wp_r == '0) ? IN_TOP : in_wp_r - 1'b1;
        end
      end
      S_FF: begin
        issue       = 1'b1;
        issue_use_x = (idx_r == '0);
        issue_zero  = (idx_r > fill_in_r);
        if (idx_r == FF_LAST) begin
          state_nxt  = S_FB;
          idx_nxt    = TAP_W'(1);
          out_rp_nxt = (out_wp_r == '0) ? OUT_TOP : out_wp_r - 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r != '0) begin
            in_rp_nxt = (in_rp_r == '0) ? IN_TOP : in_rp_r - 1'b1;
          end
        end
      end
      S_FB: begin
        issue         = 1'b1;
        issue_zero    = (idx_r > fill_out_r);
        issue_sel_out = 1'b1;
        issue_coef    = -fb_coef(idx_r[FB_IDX_W-1:0]);
        if (idx_r == FB_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt    = idx_r + 1'b1;
          out_rp_nxt = (out_rp_r == '0) ? OUT_TOP : out_rp_r - 1'b1;
        end
      end
      S_DRAIN: begin
        // The last product is accumulated at the edge that leaves this state.
        if (!b_valid_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (!out_valid_r || out_ready) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  iaf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (IN_DEPTH)
  ) u_in_hist (
    .clk   (clk),
    .we    (finish && (IN_HIST > 0)),
    .waddr (in_wp_r),
    .wdata (x_r),
    .raddr (in_rp_r),
    .rdata (in_rd)
  );

  iaf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (OUT_HIST)
  ) u_out_hist (
    .clk   (clk),
    .we    (finish),
    .waddr (out_wp_r),
    .wdata (y_val),
    .raddr (out_rp_r),
    .rdata (out_rd)
  );

  assign b_data  = b_sel_out_r ? out_rd : in_rd;
  assign operand = b_use_x_r ? x_r : (b_zero_r ? '0 : $signed(b_data));
  assign prod_w  = coef_b_r * operand;

  // Round half up, then clip when the sample's sign bit and the bits above it disagree.
  assign rnd    = acc_r + HALF;
  assign y_full = rnd[ACC_W-1:COEF_FRAC_BITS];
  assign y_hi   = y_full[YW-1:SAMPLE_BITS-1];
  assign y_sat  = (|y_hi) && !(&y_hi);
  assign y_val  = y_sat ? (y_full[YW-1] ? Y_MIN : Y_MAX) : y_full[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      in_rp_r     <= '0;
      out_rp_r    <= '0;
      in_wp_r     <= '0;
      out_wp_r    <= '0;
      fill_in_r   <= '0;
      fill_out_r  <= '0;
      b_valid_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      in_rp_r   <= in_rp_nxt;
      out_rp_r  <= out_rp_nxt;
      b_valid_r <= issue;
      p_valid_r <= b_valid_r;
      if (accept && in_start_of_signal) begin
        fill_in_r  <= '0;
        fill_out_r <= '0;
      end
      if (finish) begin
        if (IN_HIST > 0) begin
          in_wp_r <= (in_wp_r == IN_TOP) ? '0 : in_wp_r + 1'b1;
        end
        out_wp_r <= (out_wp_r == OUT_TOP) ? '0 : out_wp_r + 1'b1;
        if (fill_in_r < IN_FULL) begin
          fill_in_r <= fill_in_r + 1'b1;
        end
        if (fill_out_r < OUT_FULL) begin
          fill_out_r <= fill_out_r + 1'b1;
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_sample_in;
    end
    b_use_x_r   <= issue_use_x;
    b_zero_r    <= issue_zero;
    b_sel_out_r <= issue_sel_out;
    coef_b_r    <= issue_coef;
    prod_r      <= prod_w;
    if (accept) begin
      acc_r <= '0;
    end else if (p_valid_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (finish) begin
      out_sample_r <= y_val;
      out_sat_r    <= y_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  a_round_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && (!out_valid_r || out_ready)) |=> out_valid)
    else $error("finished sample did not reach the output register");

  a_pipe_empty_at_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (!b_valid_r && !p_valid_r))
    else $error("rounding started with taps still in flight");

  a_sat_is_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_sample_out == Y_MAX || out_sample_out == Y_MIN))
    else $error("saturated result is not a range bound");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_in_r <= IN_FULL) && (fill_out_r <= OUT_FULL))
    else $error("history fill count beyond history depth");

endmodule

`default_nettype wire

### tb/sv/tb_iir_audio_filter.sv
`timescale 1ns / 1ps

module tb_iir_audio_filter;

  localparam int SW            = iaf_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC          = iaf_pkg::COEF_FRAC_BITS_DEF;
  localparam int FF_TAPS       = iaf_pkg::FEED_FORWARD_TAPS_DEF;
  localparam int FB_TAPS       = iaf_pkg::FEEDBACK_TAPS_DEF;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_PRINTED   = 20;

  localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  localparam logic signed [SW-1:0] FULL_POS = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] FULL_NEG = {1'b1, {(SW - 1){1'b0}}};

  // Low-pass section b[k] and the feedback section a[j] in Q1.14; a[0] is implied.
  localparam int FF_COEF [FF_TAPS] = '{
      35,    59,    95,   144,   205,   277,   360,
     452,   552,   658,   769,   882,   996,  1108,
    1216,  1318,  1412,  1496,  1568,  1626,  1668,
    1694,  1701,  1690,  1659,  1609,  1539,  1450,
    1342,  1216,  1075,   918,   749,   569,   379,
     183,   -18,  -220,  -422,  -620,  -811,  -995,
   -1167, -1326, -1469, -1595, -1702, -1788, -1853
  };

  localparam int FB_COEF [FB_TAPS] = '{
       0, -15565, 13926, -12288, 10650, -9011, 7373, -5734, 4096, -2458, 819,
    -492,    164,  -131,     82,   -49,    16,   -13,     8,    -5,     2
  };

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 sat;
  } filt_result_t;

  typedef enum int {
    SEG_NOISE,
    SEG_STEP,
    SEG_ALT,
    SEG_QUIET,
    SEG_IMPULSE
  } seg_kind_t;

  logic          clk;
  logic          rst_n              = 1'b0;
  logic          in_valid           = 1'b0;
  logic          in_ready;
  logic [SW-1:0] in_sample_in       = '0;
  logic          in_start_of_signal = 1'b0;
  logic          out_valid;
  logic          out_ready          = 1'b0;
  logic [SW-1:0] out_sample_out;
  logic          out_saturated;

  logic signed [SW-1:0] x_hist [FF_TAPS-1];
  logic signed [SW-1:0] y_hist [FB_TAPS-1];

  filt_result_t pending_results [$];
  filt_result_t last_result;

  bit          idle_in   = 1'b1;
  bit          stall_out = 1'b1;
  int unsigned samples_sent = 0;
  int unsigned restarts     = 0;
  int unsigned results_seen = 0;
  int unsigned clipped_seen = 0;
  int unsigned drain_pauses = 0;
  int unsigned mismatches   = 0;

  iir_audio_filter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_in       (in_sample_in),
    .in_start_of_signal (in_start_of_signal),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_out     (out_sample_out),
    .out_saturated      (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;
  end

  // One filter step: exact sum of products, round half up, clip, then shift histories.
  function automatic filt_result_t filter_step(input logic signed [SW-1:0] x,
                                               input logic restart);
    filt_result_t r;
    longint       acc;
    longint       rounded;
    int           k;
    if (restart) begin
      foreach (x_hist[i]) x_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
    end
    acc = longint'(FF_COEF[0]) * longint'(x);
    for (k = 1; k < FF_TAPS; k++)
      acc += longint'(FF_COEF[k]) * longint'(x_hist[k-1]);
    for (k = 1; k < FB_TAPS; k++)
      acc -= longint'(FB_COEF[k]) * longint'(y_hist[k-1]);
    rounded = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    r.sat = 1'b0;
    if (rounded > SAT_HI) begin
      rounded = SAT_HI;
      r.sat = 1'b1;
    end else if (rounded < SAT_LO) begin
      rounded = SAT_LO;
      r.sat = 1'b1;
    end
    r.sample = rounded[SW-1:0];
    for (k = FF_TAPS - 2; k > 0; k--) x_hist[k] = x_hist[k-1];
    x_hist[0] = x;
    for (k = FB_TAPS - 2; k > 0; k--) y_hist[k] = y_hist[k-1];
    y_hist[0] = r.sample;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Called at a rising edge; returns at the edge where the sample is transferred,
  // with in_valid still high so that a back-to-back sample keeps it high.
  task automatic send_sample(input logic signed [SW-1:0] value, input logic restart);
    int unsigned gap;
    gap = idle_in ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sample_in       <= value;
    in_start_of_signal <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_result = filter_step(value, restart);
    pending_results.push_back(last_result);
    samples_sent++;
    if (restart) restarts++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
    drain_pauses++;
  endtask

  function automatic logic signed [SW-1:0] random_sample();
    bit [31:0] r;
    r = $urandom;
    return r[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] random_level();
    if ($urandom_range(0, 1) == 0)
      return ($urandom_range(0, 1) == 0) ? FULL_POS : FULL_NEG;
    return random_sample();
  endfunction

  // The first tap times 8192 lands exactly halfway between two output codes,
  // so both signs of a tie are seen right after a restart.
  task automatic test_rounding_ties();
    send_sample(8192, 1'b1);
    send_sample(-8192, 1'b1);
  endtask

  task automatic test_extremes_and_impulse();
    send_sample(FULL_POS, 1'b1);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(FULL_NEG, 1'b1);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
  endtask

  // A restart in the middle of a signal must forget the nonzero history.
  task automatic test_restart();
    send_sample(FULL_POS, 1'b0);
    send_sample(1, 1'b1);
    send_sample(0, 1'b0);
  endtask

  // Full-scale steps, at most 40 each, run until the output clips high, then low.
  task automatic test_overflow();
    int n;
    n = 1;
    send_sample(FULL_POS, 1'b1);
    while (!(last_result.sat && !last_result.sample[SW-1]) && n < 40) begin
      send_sample(FULL_POS, 1'b0);
      n++;
    end
    n = 1;
    send_sample(FULL_NEG, 1'b0);
    while (!(last_result.sat && last_result.sample[SW-1]) && n < 40) begin
      send_sample(FULL_NEG, 1'b0);
      n++;
    end
  endtask

  // Mostly signal-like segments with random content, each with its own idling mode.
  task automatic test_random_segments();
    seg_kind_t            kind;
    logic signed [SW-1:0] level;
    logic signed [SW-1:0] value;
    logic                 restart;
    logic                 seg_restart;
    int                   len;
    int                   q;
    int                   seg;
    int                   i;
    int unsigned          target;
    target = samples_sent + RANDOM_ITEMS;
    seg = 0;
    while (samples_sent < target) begin
      kind        = seg_kind_t'($urandom_range(0, 4));
      len         = (kind == SEG_STEP) ? $urandom_range(20, 90) : $urandom_range(8, 60);
      level       = random_level();
      seg_restart = ($urandom_range(0, 2) == 0);
      idle_in     = ($urandom_range(0, 3) != 0);
      stall_out   = ($urandom_range(0, 3) != 0);
      for (i = 0; i < len; i++) begin
        restart = (i == 0) ? seg_restart : ($urandom_range(0, 99) == 0);
        case (kind)
          SEG_NOISE: begin
            value = random_sample();
          end
          SEG_STEP: begin
            value = level;
          end
          SEG_ALT: begin
            value = i[0] ? level : ~level;
          end
          SEG_QUIET: begin
            q = int'($urandom_range(0, 128)) - 64;
            value = q[SW-1:0];
          end
          default: begin
            value = (i == 0) ? level : '0;
          end
        endcase
        send_sample(value, restart);
      end
      if (seg == 0 || $urandom_range(0, 7) == 0)
        wait_for_results();
      seg++;
    end
  endtask

  initial begin : result_monitor
    filt_result_t want;
    int unsigned  hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no sample pending",
                                    results_seen));
        end else begin
          want = pending_results.pop_front();
          if (out_sample_out !== want.sample)
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      results_seen, $signed(out_sample_out), want.sample));
          if (out_saturated !== want.sat)
            report_mismatch($sformatf("result %0d: saturated %b, expected %b",
                                      results_seen, out_saturated, want.sat));
          if (want.sat) clipped_seen++;
        end
        hold = stall_out ? $urandom_range(0, 16) : 0;
        if (hold != 0) out_ready <= 1'b0;
      end else if (!out_ready && rst_n) begin
        if (hold != 0) hold--;
        if (hold == 0) out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when neither channel has made a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timed out after %0d cycles without a transfer, %0d results outstanding.",
             QUIET_LIMIT, pending_results.size());
    $display("** iir_audio_filter: FAILED **");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rounding_ties();
    test_extremes_and_impulse();
    test_restart();
    stall_out = 1'b0;
    test_overflow();
    stall_out = 1'b1;
    test_random_segments();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d samples, %0d of them restarting the signal, with %0d drain pauses.",
             samples_sent, restarts, drain_pauses);
    $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
             results_seen, clipped_seen, mismatches);
    if (mismatches == 0)
      $display("** iir_audio_filter: PASSED **");
    else
      $display("** iir_audio_filter: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/core/iaf_pkg.sv
rtl/core/iaf_ram.sv
rtl/core/iir_audio_filter.sv
tb/sv/tb_iir_audio_filter.sv
